FILE: sv/adn_pkg.sv
// Shared types and constants for the axis dead band normalizer.
// No dependencies; imported by every module of the block.
package adn_pkg;

	localparam int REG_W   = 16;
	localparam int Q_BITS  = 16;
	localparam int DEN_W   = 32;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_AXIS_MIN       = 3'd0;
	localparam logic [IDX_W-1:0] REG_AXIS_CENTER    = 3'd1;
	localparam logic [IDX_W-1:0] REG_AXIS_MAX       = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEAD_BAND      = 3'd3;
	localparam logic [IDX_W-1:0] REG_SATURATE_POINT = 3'd4;

	localparam logic signed [15:0] FULL_POS = 16'sh7FFF;
	localparam logic signed [15:0] FULL_NEG = 16'sh8000;
	localparam logic [Q_BITS-1:0]  Q_MAX    = 16'h7FFF;

	typedef enum logic [1:0] {
		CLS_FAULT,
		CLS_ZERO,
		CLS_FULL,
		CLS_DIV
	} cls_t;

	typedef struct packed {
		logic [REG_W-1:0] axis_min;
		logic [REG_W-1:0] axis_center;
		logic [REG_W-1:0] axis_max;
		logic [REG_W-1:0] dead_band;
		logic [REG_W-1:0] saturate_point;
	} cfg_t;

	// one beat travelling down the divider chain
	typedef struct packed {
		logic              valid;
		cls_t              cls;
		logic              below;
		logic [DEN_W:0]    rem;
		logic [DEN_W-1:0]  den;
		logic [Q_BITS-1:0] quo;
	} div_beat_t;

endpackage

FILE: sv/adn_front.sv
// Front pipeline: side select, fraction compares and divider operands.
// Depends on adn_pkg.
module adn_front #(
	parameter int RAW_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [RAW_BITS-1:0]    raw_value,
	input  adn_pkg::cfg_t          cfg,
	output adn_pkg::div_beat_t     beat
);
	import adn_pkg::*;

	localparam int NW = (RAW_BITS > REG_W) ? RAW_BITS : REG_W;
	localparam int SW = NW + 15;
	localparam int CW = (SW > DEN_W) ? SW : DEN_W;

	logic [NW-1:0] x_ext, c_ext, n_c;
	logic          below_c, dfault_c;
	logic [REG_W-1:0] d_c;

	logic             v_s1, below_s1, dfault_s1;
	logic [NW-1:0]    n_s1;
	logic [REG_W-1:0] d_s1;

	logic             v_s2, below_s2, dfault_s2;
	logic [SW-1:0]    scaled_s2;
	logic [DEN_W-1:0] hi_s2, lo_s2, den_s2;

	logic             v_s3, below_s3;
	cls_t             cls_s3;
	logic [DEN_W-1:0] r_s3, den_s3;

	logic [CW-1:0] scaled_w, hi_w, lo_w, diff_w;
	logic          gt_c, lt_c;
	cls_t          cls_c;
	logic [REG_W-1:0] span_c;

	// stage 1: side of center, distance and half travel
	always_comb begin
		x_ext   = NW'(raw_value);
		c_ext   = NW'(cfg.axis_center);
		below_c = x_ext < c_ext;
		n_c     = below_c ? (c_ext - x_ext) : (x_ext - c_ext);
		if (below_c) begin
			dfault_c = cfg.axis_min >= cfg.axis_center;
			d_c      = cfg.axis_center - cfg.axis_min;
		end else begin
			dfault_c = cfg.axis_max <= cfg.axis_center;
			d_c      = cfg.axis_max - cfg.axis_center;
		end
	end

	// stage 2 products; span only matters when saturate_point > dead_band
	assign span_c = cfg.saturate_point - cfg.dead_band;

	// stage 3: classify against the dead band and saturation thresholds
	always_comb begin
		scaled_w = CW'(scaled_s2);
		hi_w     = CW'(hi_s2);
		lo_w     = CW'(lo_s2);
		diff_w   = scaled_w - lo_w;
		gt_c     = scaled_w > hi_w;
		lt_c     = scaled_w < lo_w;
		priority if (dfault_s2)
			cls_c = CLS_FAULT;
		else if (gt_c)
			cls_c = CLS_FULL;
		else if (lt_c)
			cls_c = CLS_ZERO;
		else if (cfg.saturate_point == cfg.dead_band)
			cls_c = CLS_FAULT;
		else
			cls_c = CLS_DIV;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			below_s1  <= below_c;
			dfault_s1 <= dfault_c;
			n_s1      <= n_c;
			d_s1      <= d_c;

			below_s2  <= below_s1;
			dfault_s2 <= dfault_s1;
			scaled_s2 <= {n_s1, 15'b0};
			hi_s2     <= DEN_W'(cfg.saturate_point) * DEN_W'(d_s1);
			lo_s2     <= DEN_W'(cfg.dead_band) * DEN_W'(d_s1);
			den_s2    <= DEN_W'(span_c) * DEN_W'(d_s1);

			below_s3  <= below_s2;
			cls_s3    <= cls_c;
			r_s3      <= diff_w[DEN_W-1:0];
			den_s3    <= den_s2;
		end
	end

	always_comb begin
		beat.valid = v_s3;
		beat.cls   = cls_s3;
		beat.below = below_s3;
		beat.rem   = {1'b0, r_s3};
		beat.den   = den_s3;
		beat.quo   = '0;
	end

endmodule

FILE: sv/adn_div_cell.sv
// One restoring-division cell: resolves one quotient bit per beat.
// Depends on adn_pkg.
module adn_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  adn_pkg::div_beat_t beat_in,
	output adn_pkg::div_beat_t beat_out
);
	import adn_pkg::*;

	div_beat_t        beat_q;
	logic             ge;
	logic [DEN_W:0]   trial;

	always_comb begin
		ge    = beat_in.rem >= {1'b0, beat_in.den};
		trial = ge ? (beat_in.rem - {1'b0, beat_in.den}) : beat_in.rem;
	end

	// remainder after the trial is below den, so doubling fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (en) begin
			beat_q.valid <= beat_in.valid;
			beat_q.cls   <= beat_in.cls;
			beat_q.below <= beat_in.below;
			beat_q.den   <= beat_in.den;
			beat_q.rem   <= {trial[DEN_W-1:0], 1'b0};
			beat_q.quo   <= {beat_in.quo[Q_BITS-2:0], ge};
		end
	end

	assign beat_out = beat_q;

endmodule

FILE: sv/adn_out.sv
// Result formatting and output register with skid slot.
// Depends on adn_pkg.
module adn_out (
	input  logic               clk,
	input  logic               arst_n,
	input  adn_pkg::div_beat_t beat,
	output logic               up_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] axis_value,
	output logic               fault
);
	import adn_pkg::*;

	logic signed [15:0] val_c, val_q, skid_val_q;
	logic               flt_c, flt_q, skid_flt_q;
	logic               out_v_q, skid_v_q, up_fire;

	always_comb begin
		flt_c = 1'b0;
		unique case (beat.cls)
			CLS_FAULT: begin
				val_c = '0;
				flt_c = 1'b1;
			end
			CLS_ZERO: val_c = '0;
			CLS_FULL: val_c = beat.below ? FULL_NEG : FULL_POS;
			CLS_DIV: begin
				if (beat.below)
					val_c = -$signed(beat.quo);
				else
					val_c = (beat.quo > Q_MAX) ? FULL_POS : $signed(beat.quo);
			end
			default: val_c = '0;
		endcase
	end

	assign up_ready = !skid_v_q;
	assign up_fire  = beat.valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= up_fire;
			end
		end else if (up_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				val_q <= skid_val_q;
				flt_q <= skid_flt_q;
			end else if (up_fire) begin
				val_q <= val_c;
				flt_q <= flt_c;
			end
		end else if (up_fire) begin
			skid_val_q <= val_c;
			skid_flt_q <= flt_c;
		end
	end

	assign out_valid  = out_v_q;
	assign axis_value = val_q;
	assign fault      = flt_q;

endmodule

FILE: sv/axis_deadband_normalizer_top.sv
// Joystick axis dead band normalizer, top level. Uses adn_pkg, adn_front,
// adn_div_cell and adn_out.
// Pipeline: 3 front stages, 16 divider cells and the output register.
// Throughput: one beat per cycle while the output skid slot is free,
// set by the 16-cell restoring divider chain, one quotient bit per cell.
// Reset: arst_n clears all valid flags and loads the calibration defaults.
module axis_deadband_normalizer_top #(
	parameter int RAW_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic [RAW_BITS-1:0] raw_value,

	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  axis_value,
	output logic                fault,

	input  logic                cfg_we,
	input  logic [adn_pkg::IDX_W-1:0] cfg_index,
	input  logic [adn_pkg::REG_W-1:0] cfg_data
);
	import adn_pkg::*;

	// Calibration registers. The user must make writes only while idle; the
	// block does not enforce it. The pipeline's front stages read them live.
	cfg_t cfg_q;

	// Pipeline advance. Every stage moves while the skid slot at the
	// output is free; a waiting output beat parks in the skid slot, so
	// in_ready is a register and does not follow out_ready combinationally.
	logic en;

	// chain[0] comes from the front stages, chain[Q_BITS] feeds the output
	div_beat_t chain [0:Q_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_min       <= 16'd0;
			cfg_q.axis_center    <= 16'd32768;
			cfg_q.axis_max       <= 16'd65535;
			cfg_q.dead_band      <= 16'd0;
			cfg_q.saturate_point <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AXIS_MIN:       cfg_q.axis_min       <= cfg_data;
				REG_AXIS_CENTER:    cfg_q.axis_center    <= cfg_data;
				REG_AXIS_MAX:       cfg_q.axis_max       <= cfg_data;
				REG_DEAD_BAND:      cfg_q.dead_band      <= cfg_data;
				REG_SATURATE_POINT: cfg_q.saturate_point <= cfg_data;
				default: ; // unknown index: write dropped
			endcase
		end
	end

	assign in_ready = en;

	// Front: side of center, distance, half travel, threshold products
	// and the classification (fault, dead band, full scale, rescale).
	adn_front #(
		.RAW_BITS (RAW_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.raw_value (raw_value),
		.cfg       (cfg_q),
		.beat      (chain[0])
	);

	// Divider chain: quotient MSB first, one cell per bit. The dividend
	// never exceeds the divisor, so 16 bits cover quotients up to 1.0.
	for (genvar k = 0; k < Q_BITS; k++) begin : g_cell
		adn_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.beat_in  (chain[k]),
			.beat_out (chain[k+1])
		);
	end

	// Sign, clamp to 32767 on the positive side, output register + skid.
	adn_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (chain[Q_BITS]),
		.up_ready   (en),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.axis_value (axis_value),
		.fault      (fault)
	);

endmodule

FILE: verif/tb_axis_deadband_normalizer_top.sv
// Testbench for axis_deadband_normalizer_top: directed and random raw samples under
// many calibrations, checked against an in-bench integer predictor.
// Depends on adn_pkg and axis_deadband_normalizer_top.
module tb_axis_deadband_normalizer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import adn_pkg::*;

	localparam int RAW_BITS    = 16;
	localparam int RESET_CYC   = 12;
	localparam int SETTLE_CYC  = 24;      // pipeline depth is 20, plus margin
	localparam int HOLD_CYC    = 300;     // long receiver hold-off
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 7;
	localparam int PHASE_BEATS = 52;
	localparam int FLOOD_BEATS = 80;
	localparam int MAX_SHOWN   = 10;

	// one predicted output beat, tagged with the sample that caused it
	typedef struct {
		logic [15:0]        raw;
		logic signed [15:0] value;
		logic               fault;
	} axis_expect_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [RAW_BITS-1:0] raw_value;
	logic                out_valid;
	logic                out_ready;
	logic signed [15:0]  axis_value;
	logic                fault;
	logic                cfg_we;
	logic [IDX_W-1:0]    cfg_index;
	logic [REG_W-1:0]    cfg_data;

	cfg_t         cal;            // predictor's copy of the calibration registers
	axis_expect_t axis_q[$];      // predicted beats, oldest first
	int           mismatches;
	int           cycles;
	bit           hold_req;
	bit           hold_active;

	axis_deadband_normalizer_top #(.RAW_BITS(RAW_BITS)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_value  (raw_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.axis_value (axis_value),
		.fault      (fault),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	// Exact integer normalization of one sample under the current calibration.
	function automatic axis_expect_t normalize_sample(input logic [15:0] raw);
		axis_expect_t r;
		longint       span;
		bit [63:0]    n, d, scaled, lo, hi, num, den, q, neg;
		bit           below;
		r.raw   = raw;
		r.value = '0;
		r.fault = 1'b0;
		below = (raw < cal.axis_center);
		// half travel on the side the sample lies on; distance from center
		if (below) begin
			span = longint'({48'd0, cal.axis_center}) - longint'({48'd0, cal.axis_min});
			n    = {48'd0, cal.axis_center} - {48'd0, raw};
		end else begin
			span = longint'({48'd0, cal.axis_max}) - longint'({48'd0, cal.axis_center});
			n    = {48'd0, raw} - {48'd0, cal.axis_center};
		end
		if (span <= 0) begin
			// zero or inverted half travel
			r.fault = 1'b1;
			return r;
		end
		d      = 64'(span);
		scaled = n << 15;
		hi     = {48'd0, cal.saturate_point} * d;
		lo     = {48'd0, cal.dead_band} * d;
		if (scaled > hi) begin
			r.value = below ? FULL_NEG : FULL_POS;
		end else if (scaled < lo) begin
			r.value = '0;
		end else if (cal.saturate_point == cal.dead_band) begin
			// rescale window has zero width
			r.fault = 1'b1;
		end else begin
			num = (scaled - lo) << 15;
			den = ({48'd0, cal.saturate_point} - {48'd0, cal.dead_band}) * d;
			q   = num / den;
			if (q > 64'd32768)
				q = 64'd32768;
			if (below) begin
				neg     = 64'd0 - q;
				r.value = neg[15:0];
			end else begin
				if (q > 64'd32767)
					q = 64'd32767;
				r.value = q[15:0];
			end
		end
		return r;
	endfunction

	// Sender gap: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Offer one beat from a falling edge, hold it until accepted, predict it.
	// With gap 0 valid stays high so the next call can follow back to back.
	task automatic send_sample(input logic [15:0] raw, input int gap);
		in_valid  <= 1'b1;
		raw_value <= raw;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		axis_q.push_back(normalize_sample(raw));
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every predicted beat has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (axis_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// One register write; the predictor copy follows at once since the block is idle.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_AXIS_MIN:       cal.axis_min       = data;
			REG_AXIS_CENTER:    cal.axis_center    = data;
			REG_AXIS_MAX:       cal.axis_max       = data;
			REG_DEAD_BAND:      cal.dead_band      = data;
			REG_SATURATE_POINT: cal.saturate_point = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_cal(input cfg_t c);
		drain();
		write_reg(REG_AXIS_MIN,       c.axis_min);
		write_reg(REG_AXIS_CENTER,    c.axis_center);
		write_reg(REG_AXIS_MAX,       c.axis_max);
		write_reg(REG_DEAD_BAND,      c.dead_band);
		write_reg(REG_SATURATE_POINT, c.saturate_point);
	endtask

	// Reset calibration: full travel, no dead band, saturation at full scale.
	task automatic test_reset_defaults();
		send_sample(16'h0000, 0);     // full negative
		send_sample(16'hFFFF, 0);     // +1.0, clamped to 32767
		send_sample(16'h8000, 0);     // exactly at center
		send_sample(16'h7FFF, 1);
		send_sample(16'h0001, 0);
	endtask

	task automatic test_special_cases();
		cfg_t c;
		// dead band and saturation inside the travel
		c = '{axis_min: 16'd0, axis_center: 16'd32768, axis_max: 16'd65535,
			dead_band: 16'd8192, saturate_point: 16'd24576};
		set_cal(c);
		send_sample(16'd33000, 0);    // inside dead band
		send_sample(16'd65000, 0);    // past saturation
		send_sample(16'd49152, 0);    // linear region
		send_sample(16'd12000, 0);    // linear region, below center
		// equal dead band and saturation: boundary hit gives a fault
		drain();
		write_reg(REG_DEAD_BAND,      16'd16384);
		write_reg(REG_SATURATE_POINT, 16'd16384);
		send_sample(16'd16384, 0);
		send_sample(16'd32770, 0);
		// saturation below dead band
		drain();
		write_reg(REG_DEAD_BAND,      16'd20000);
		write_reg(REG_SATURATE_POINT, 16'd10000);
		send_sample(16'hFFFF, 0);
		send_sample(16'd40000, 0);
		// zero half travel below center, normal above
		c = '{axis_min: 16'd32768, axis_center: 16'd32768, axis_max: 16'd65535,
			dead_band: 16'd0, saturate_point: 16'd32768};
		set_cal(c);
		send_sample(16'd100, 0);
		send_sample(16'd40000, 0);
		// inverted half travel above center
		drain();
		write_reg(REG_AXIS_MAX, 16'd1000);
		send_sample(16'd50000, 0);
		// thresholds above one
		c = '{axis_min: 16'd0, axis_center: 16'd32768, axis_max: 16'd65535,
			dead_band: 16'd0, saturate_point: 16'hFFFF};
		set_cal(c);
		send_sample(16'hFFFF, 0);
		drain();
		write_reg(REG_DEAD_BAND, 16'hFFFF);
		send_sample(16'h8000, 0);
		// all ones, then all zeros
		c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		set_cal(c);
		send_sample(16'hFFFF, 0);
		send_sample(16'h0000, 0);
		c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
		set_cal(c);
		send_sample(16'h0000, 0);
		// indexes past the register list must leave the calibration alone
		drain();
		for (int i = int'(REG_SATURATE_POINT) + 1; i < 2**IDX_W; i++)
			write_reg(IDX_W'(i), 16'hFFFF);
		send_sample(16'h0000, 0);
	endtask

	// Random calibrations, each followed by a burst of samples with random gaps.
	task automatic test_random_phases();
		cfg_t c;
		int   span, mn, mx, db, r;
		bit   sane;
		for (int p = 0; p < PHASES; p++) begin
			sane = (p == 0) || ($urandom_range(0, 9) < 7);
			if (sane) begin
				c.axis_center = 16'($urandom_range(0, 65535));
				span = 1 << $urandom_range(0, 16);
				mn = int'(c.axis_center) - int'($urandom_range(1, span));
				mx = int'(c.axis_center) + int'($urandom_range(1, span));
				if (mn < 0)
					mn = 0;
				if (mx > 65535)
					mx = 65535;
				db = int'($urandom_range(0, 32768));
				c.axis_min       = 16'(mn);
				c.axis_max       = 16'(mx);
				c.dead_band      = 16'(db);
				c.saturate_point = 16'($urandom_range(db, 32768));
			end else begin
				c = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom)};
				mn = 0;
				mx = 65535;
			end
			set_cal(c);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 70 && mn <= mx)
					send_sample(16'($urandom_range(mn, mx)), pick_gap());
				else if (r < 85)
					send_sample(c.axis_center + 16'($urandom_range(0, 128)) - 16'd64,
						pick_gap());
				else
					send_sample(16'($urandom), pick_gap());
			end
		end
	endtask

	// Receiver holds off for a long stretch while the sender floods the input.
	task automatic test_backpressure();
		drain();
		hold_req = 1'b1;
		while (!hold_active)
			@(negedge clk);
		for (int i = 0; i < FLOOD_BEATS; i++)
			send_sample(16'($urandom), 0);
	endtask

	// Receiver: random ready pattern, plus a long hold-off on request.
	initial begin
		int r;
		int len;
		out_ready   = 1'b0;
		hold_active = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_ready   <= 1'b0;
				hold_active = 1'b1;
				repeat (HOLD_CYC) @(negedge clk);
				hold_req    = 1'b0;
				hold_active = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					out_ready <= 1'b0;
					len = $urandom_range(15, 60);
				end else if (r < 40) begin
					out_ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b1;
					len = $urandom_range(1, 30);
				end
				repeat (len) @(negedge clk);
			end
		end
	end

	// Every output beat is matched against the oldest prediction.
	always @(posedge clk) begin
		axis_expect_t want;
		if (arst_n && out_valid && out_ready) begin
			if (axis_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected beat: axis_value=%0d fault=%0b", axis_value, fault);
			end else begin
				want = axis_q.pop_front();
				if (axis_value !== want.value || fault !== want.fault) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch raw=%0d: expected axis_value=%0d fault=%0b, got axis_value=%0d fault=%0b",
							want.raw, want.value, want.fault, axis_value, fault);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		hold_req   = 1'b0;
		in_valid   = 1'b0;
		raw_value  = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		cal = '{axis_min: 16'd0, axis_center: 16'd32768, axis_max: 16'd65535,
			dead_band: 16'd0, saturate_point: 16'd32768};
		arst_n = 1'b0;
		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_special_cases();
		test_random_phases();
		test_backpressure();
		drain();

		if (mismatches == 0 && axis_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
